// File: hdl/g2e_pkg.sv
// Package for the geodetic to ECEF offset core: types, constants and elaboration-time tables.
package g2e_pkg;

	localparam int CORDIC_STAGES_DEF = 32;
	localparam int ATAN_SLOTS = 48;
	localparam int NEWTON_STEPS = 8;

	localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
	localparam logic [63:0] THREE_Q60 = 64'h3000_0000_0000_0000;
	localparam logic [63:0] A_MM = 64'd6378137000;
	localparam logic [63:0] E2_Q60 = 64'd7718094650643700;
	localparam logic [63:0] ONE_MINUS_E2_Q60 = ONE_Q60 - E2_Q60;

	// Configuration register indexes.
	localparam logic [1:0] REG_ORG_LAT = 2'd0;
	localparam logic [1:0] REG_ORG_LON = 2'd1;
	localparam logic [1:0] REG_ORG_HGT = 2'd2;

	// Series selectors for the arctangent tables.
	localparam int ATAN_SEL_5 = 0;
	localparam int ATAN_SEL_239 = 1;
	localparam int ATAN_SEL_POW2 = 2;

	typedef struct packed {
		logic               valid;
		logic signed [63:0] x_lat;
		logic signed [63:0] y_lat;
		logic signed [63:0] z_lat;
		logic signed [63:0] x_lon;
		logic signed [63:0] y_lon;
		logic signed [63:0] z_lon;
		logic               flip;
		logic signed [27:0] h;
		logic               tag;
	} cordic_beat_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// Rounded (a*b) >> sh, low 64 bits; used only at elaboration.
	function automatic logic [63:0] mulsh(input logic [63:0] a, input logic [63:0] b,
			input int sh);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		if (sh > 0) begin
			prod = prod + (128'd1 << (sh - 1));
		end
		prod = prod >> sh;
		return prod[63:0];
	endfunction

	// Taylor series of atan(1/n) in Q62 with truncated terms.
	function automatic logic [63:0] atan_series(input int sel, input int sh);
		logic [63:0] p;
		logic [63:0] sum;
		logic        stop;
		int          k;
		case (sel)
			ATAN_SEL_5: p = (64'd1 << 62) / 64'd5;
			ATAN_SEL_239: p = (64'd1 << 62) / 64'd239;
			default: p = (64'd1 << 62) >> sh;
		endcase
		sum = p;
		stop = 1'b0;
		for (k = 1; k < 64; k++) begin
			if (!stop) begin
				case (sel)
					ATAN_SEL_5: p = p / 64'd25;
					ATAN_SEL_239: p = p / 64'd57121;
					default: p = p >> (2 * sh);
				endcase
				if (p == 64'd0) begin
					stop = 1'b1;
				end else if (k[0]) begin
					sum = sum - p / 64'(2 * k + 1);
				end else begin
					sum = sum + p / 64'(2 * k + 1);
				end
			end
		end
		return sum;
	endfunction

	// Angle of CORDIC stage i in Q62; stage zero holds pi/4.
	function automatic logic [63:0] atan_q62(input int i);
		if (i == 0) begin
			return 64'(4 * atan_series(ATAN_SEL_5, 0)) - atan_series(ATAN_SEL_239, 0);
		end
		return atan_series(ATAN_SEL_POW2, i);
	endfunction

	// Inverse CORDIC gain in Q60 for the given number of stages.
	function automatic logic [63:0] inv_gain_q60(input int stages);
		logic [63:0] p;
		logic [63:0] y;
		logic [63:0] u;
		logic [63:0] v;
		int          i;
		p = ONE_Q60;
		for (i = 0; i < ATAN_SLOTS; i++) begin
			if (i < stages && 2 * i < 64) begin
				p = p + (p >> (2 * i));
			end
		end
		y = ONE_Q60 / 64'd5 * 64'd3;
		for (i = 0; i < NEWTON_STEPS; i++) begin
			u = mulsh(p, mulsh(y, y, 60), 60);
			v = (u >= THREE_Q60) ? 64'd0 : THREE_Q60 - u;
			y = mulsh(y, v, 61);
		end
		return y;
	endfunction

	// Degrees*1e7 to radians Q62: integer part and 32 bit fraction of pi*2^62/1.8e9.
	localparam logic [63:0] PI_Q61 = atan_q62(0) << 1;
	localparam logic [63:0] DEG180_U = 64'd1800000000;
	localparam logic [63:0] K_Q = PI_Q61 / DEG180_U;
	localparam logic [63:0] K_R = PI_Q61 % DEG180_U;
	localparam logic [63:0] K_F = (K_R << 33) / DEG180_U;
	localparam logic [32:0] K_INT = 33'((K_Q << 1) + (K_F >> 32));
	localparam logic [31:0] K_FRAC = K_F[31:0];

endpackage

// File: hdl/g2e_mul.sv
// Two-stage 64x64 multiplier with rounded right shift and sign, built from 32x32 products.
module g2e_mul #(
	parameter int SH = 60,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	input  logic [63:0]   a,
	input  logic [63:0]   b,
	input  logic          neg,
	input  logic [SW-1:0] side,
	output logic          res_valid,
	output logic [63:0]   res,
	output logic [SW-1:0] res_side
);

	localparam logic [127:0] RND = 128'd1 << (SH - 1);

	logic          vld_s1;
	logic          vld_s2;
	logic [63:0]   pp_ll_s1;
	logic [63:0]   pp_lh_s1;
	logic [63:0]   pp_hl_s1;
	logic [63:0]   pp_hh_s1;
	logic          neg_s1;
	logic [SW-1:0] side_s1;
	logic [SW-1:0] side_s2;
	logic [63:0]   res_s2;
	logic [127:0]  full;
	logic [127:0]  shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pp_ll_s1 <= a[31:0] * b[31:0];
		pp_lh_s1 <= a[31:0] * b[63:32];
		pp_hl_s1 <= a[63:32] * b[31:0];
		pp_hh_s1 <= a[63:32] * b[63:32];
		neg_s1 <= neg;
		side_s1 <= side;
	end

	always_comb begin
		full = {64'd0, pp_ll_s1} + {32'd0, pp_lh_s1, 32'd0} + {32'd0, pp_hl_s1, 32'd0}
			+ {pp_hh_s1, 64'd0} + RND;
		shifted = full >> SH;
	end

	always_ff @(posedge clk) begin
		res_s2 <= neg_s1 ? 64'(-shifted[63:0]) : shifted[63:0];
		side_s2 <= side_s1;
	end

	assign res_valid = vld_s2;
	assign res = res_s2;
	assign res_side = side_s2;

endmodule

// File: hdl/g2e_cordic_cell.sv
// One CORDIC rotation stage for the latitude and longitude lanes.
module g2e_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  g2e_pkg::cordic_beat_t d,
	output g2e_pkg::cordic_beat_t q
);

	localparam logic signed [63:0] ATAN = signed'(g2e_pkg::atan_q62(IDX));

	g2e_pkg::cordic_beat_t nxt;
	g2e_pkg::cordic_beat_t pay_q;
	logic                  vld_q;

	always_comb begin
		nxt = d;
		if (d.z_lat >= 0) begin
			nxt.x_lat = d.x_lat - (d.y_lat >>> IDX);
			nxt.y_lat = d.y_lat + (d.x_lat >>> IDX);
			nxt.z_lat = d.z_lat - ATAN;
		end else begin
			nxt.x_lat = d.x_lat + (d.y_lat >>> IDX);
			nxt.y_lat = d.y_lat - (d.x_lat >>> IDX);
			nxt.z_lat = d.z_lat + ATAN;
		end
		if (d.z_lon >= 0) begin
			nxt.x_lon = d.x_lon - (d.y_lon >>> IDX);
			nxt.y_lon = d.y_lon + (d.x_lon >>> IDX);
			nxt.z_lon = d.z_lon - ATAN;
		end else begin
			nxt.x_lon = d.x_lon + (d.y_lon >>> IDX);
			nxt.y_lon = d.y_lon - (d.x_lon >>> IDX);
			nxt.z_lon = d.z_lon + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= nxt;
	end

	always_comb begin
		q = pay_q;
		q.valid = vld_q;
	end

endmodule

// File: hdl/g2e_newton_cell.sv
// One Newton step of the inverse square root: y <- y * (3 - w*y*y) / 2, all Q60.
module g2e_newton_cell #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	input  logic [63:0]   w,
	input  logic [63:0]   y,
	input  logic [SW-1:0] side,
	output logic          res_valid,
	output logic [63:0]   res_w,
	output logic [63:0]   res_y,
	output logic [SW-1:0] res_side
);

	logic               yy_v;
	logic [63:0]        yy;
	logic [SW+127:0]    yy_side;
	logic               u_v;
	logic [63:0]        u;
	logic [SW+127:0]    u_side;
	logic [63:0]        v;
	logic [63:0]        w_u;
	logic [63:0]        y_u;
	logic [SW-1:0]      side_u;

	g2e_mul #(.SH(60), .SW(SW + 128)) u_mul_yy (
		.clk, .arst_n, .valid(valid), .a(y), .b(y), .neg(1'b0), .side({w, y, side}),
		.res_valid(yy_v), .res(yy), .res_side(yy_side)
	);

	g2e_mul #(.SH(60), .SW(SW + 128)) u_mul_u (
		.clk, .arst_n, .valid(yy_v), .a(yy_side[SW+127:SW+64]), .b(yy), .neg(1'b0),
		.side(yy_side), .res_valid(u_v), .res(u), .res_side(u_side)
	);

	assign {w_u, y_u, side_u} = u_side;
	assign v = (u >= g2e_pkg::THREE_Q60) ? 64'd0 : g2e_pkg::THREE_Q60 - u;

	g2e_mul #(.SH(61), .SW(SW + 64)) u_mul_y (
		.clk, .arst_n, .valid(u_v), .a(y_u), .b(v), .neg(1'b0), .side({w_u, side_u}),
		.res_valid(res_valid), .res(res_y), .res_side({res_w, res_side})
	);

endmodule

// File: hdl/geodetic_to_local_ecef_offset_core.sv
// Top level: geodetic point to WGS84 ECEF, minus the ECEF of a configured origin.
//
//  channel   signals                                  handshake
//  ------------------------------------------------------------------------------------
//  point in  latitude, longitude, height              start & !busy takes a beat
//  config    wr_en, wr_index, wr_data                 written on every edge with wr_en
//  offset    offset_x, offset_y, offset_z             done marks a beat for one cycle
//
// The datapath is fully pipelined and takes a new point every cycle while busy is low.
// A point passes stages 1 to 3, the CORDIC cell chain, the 1 - e2 sin^2 lat multipliers,
// the Newton cells with their two-stage multipliers, the radius and x, y, z multipliers
// and the output register. After reset and after each configuration write the origin
// itself runs once through the pipeline; busy is high while a run is pending or in flight.
// The receiver cannot stall: each result is shown for exactly one cycle.
module geodetic_to_local_ecef_offset_core #(
	parameter int CORDIC_STAGES = g2e_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [30:0] latitude,
	input  logic signed [31:0] longitude,
	input  logic signed [27:0] height,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data,
	output logic               done,
	output logic signed [34:0] offset_x,
	output logic signed [34:0] offset_y,
	output logic signed [34:0] offset_z
);

	localparam int NS = g2e_pkg::NEWTON_STEPS;
	localparam int SIDE_W = 4 * 64 + 28 + 1;
	localparam logic [63:0] INV_GAIN = g2e_pkg::inv_gain_q60(CORDIC_STAGES);
	localparam logic signed [30:0] LAT_MAX = 31'sd900000000;
	localparam logic signed [33:0] LON_90 = 34'sd900000000;
	localparam logic signed [33:0] LON_180 = 34'sd1800000000;
	localparam logic signed [33:0] LON_360 = 34'sd3600000000;
	localparam logic signed [64:0] OUT_LIM = 65'sd14000000000;

	// Configuration and origin sequencing.
	logic signed [30:0] org_lat_q;
	logic signed [31:0] org_lon_q;
	logic signed [27:0] org_h_q;
	logic               pending_q;
	logic               inflight_q;
	logic               inject;
	logic               take;

	// Input conditioning and angle scaling.
	logic signed [30:0] src_lat;
	logic signed [31:0] src_lon;
	logic signed [27:0] src_h;
	logic signed [30:0] lat_c;
	logic signed [33:0] lon_w;
	logic               lon_flip;
	logic               vld_s1;
	logic signed [30:0] lat_s1;
	logic signed [30:0] lon_s1;
	logic               flip_s1;
	logic signed [27:0] h_s1;
	logic               tag_s1;
	logic [30:0]        lat_m;
	logic [30:0]        lon_m;
	logic               vld_s2;
	logic [62:0]        lat_pi_s2;
	logic [61:0]        lat_pf_s2;
	logic [62:0]        lon_pi_s2;
	logic [61:0]        lon_pf_s2;
	logic               lat_neg_s2;
	logic               lon_neg_s2;
	logic               flip_s2;
	logic signed [27:0] h_s2;
	logic               tag_s2;
	logic [63:0]        lat_fr;
	logic [63:0]        lon_fr;
	logic [63:0]        lat_r;
	logic [63:0]        lon_r;
	logic               vld_s3;
	g2e_pkg::cordic_beat_t beat_s3;

	g2e_pkg::cordic_beat_t chain [0:CORDIC_STAGES];
	g2e_pkg::cordic_beat_t ce;
	logic signed [63:0] cp;
	logic signed [63:0] sp;
	logic signed [63:0] cl;
	logic signed [63:0] sl;

	logic               s2_v;
	logic [63:0]        s2_p;
	logic [SIDE_W-1:0]  s2_side;
	logic               e_v;
	logic [63:0]        e_p;
	logic [SIDE_W-1:0]  e_side;

	logic               nv [0:NS];
	logic [63:0]        nw [0:NS];
	logic [63:0]        ny [0:NS];
	logic [SIDE_W-1:0]  nside [0:NS];

	logic               n_v;
	logic [63:0]        n16;
	logic [SIDE_W-1:0]  n_side;
	logic signed [63:0] cp1;
	logic signed [63:0] sp1;
	logic signed [63:0] cl1;
	logic signed [63:0] sl1;
	logic signed [27:0] h1;
	logic               tag1;
	logic signed [63:0] h16;
	logic signed [63:0] sum_n;

	logic               t_v;
	logic [63:0]        t_r;
	logic signed [63:0] cl2;
	logic signed [63:0] sl2;
	logic               tag2;
	logic               nb_v;
	logic [63:0]        nb_r;
	logic signed [63:0] sp2;
	logic signed [27:0] h2;
	logic signed [63:0] t2;
	logic signed [63:0] zs;
	logic signed [63:0] h16_2;

	logic               fx_v;
	logic               fy_v;
	logic               fz_v;
	logic [63:0]        fx_r;
	logic [63:0]        fy_r;
	logic [63:0]        fz_r;
	logic               fx_tag;
	logic               fy_tag;
	logic               fz_tag;

	logic signed [63:0] org_x_q;
	logic signed [63:0] org_y_q;
	logic signed [63:0] org_z_q;
	logic               done_q;
	logic signed [34:0] offset_x_q;
	logic signed [34:0] offset_y_q;
	logic signed [34:0] offset_z_q;

	function automatic logic signed [34:0] sat35(input logic signed [64:0] d);
		if (d > OUT_LIM) begin
			return 35'sd14000000000;
		end else if (d < -OUT_LIM) begin
			return -35'sd14000000000;
		end
		return d[34:0];
	endfunction

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_lat_q <= '0;
			org_lon_q <= '0;
			org_h_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				g2e_pkg::REG_ORG_LAT: org_lat_q <= signed'(wr_data[30:0]);
				g2e_pkg::REG_ORG_LON: org_lon_q <= signed'(wr_data);
				g2e_pkg::REG_ORG_HGT: org_h_q <= signed'(wr_data[27:0]);
				default: ;
			endcase
		end
	end

	// The origin is converted once after reset and after each write, then held.
	assign busy = pending_q | inflight_q;
	assign inject = pending_q & ~inflight_q;
	assign take = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b1;
			inflight_q <= 1'b0;
		end else begin
			if (wr_en) begin
				pending_q <= 1'b1;
			end else if (inject) begin
				pending_q <= 1'b0;
			end
			if (inject) begin
				inflight_q <= 1'b1;
			end else if (fx_v && fx_tag) begin
				inflight_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- stage 1
	always_comb begin
		src_lat = inject ? org_lat_q : latitude;
		src_lon = inject ? org_lon_q : longitude;
		src_h = inject ? org_h_q : height;
		lat_c = src_lat;
		if (src_lat > LAT_MAX) begin
			lat_c = LAT_MAX;
		end else if (src_lat < -LAT_MAX) begin
			lat_c = -LAT_MAX;
		end
		lon_w = 34'(src_lon);
		if (lon_w > LON_180) begin
			lon_w = lon_w - LON_360;
		end else if (lon_w < -LON_180) begin
			lon_w = lon_w + LON_360;
		end
		// Fold into the right half-plane; the sine and cosine flip sign later.
		lon_flip = 1'b0;
		if (lon_w > LON_90) begin
			lon_w = lon_w - LON_180;
			lon_flip = 1'b1;
		end else if (lon_w < -LON_90) begin
			lon_w = lon_w + LON_180;
			lon_flip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= inject | take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		lat_s1 <= lat_c;
		lon_s1 <= signed'(lon_w[30:0]);
		flip_s1 <= lon_flip;
		h_s1 <= src_h;
		tag_s1 <= inject;
	end

	// ---------------------------------------------------------------- stage 2
	assign lat_m = lat_s1[30] ? 31'(-lat_s1) : 31'(lat_s1);
	assign lon_m = lon_s1[30] ? 31'(-lon_s1) : 31'(lon_s1);

	always_ff @(posedge clk) begin
		lat_pi_s2 <= lat_m[29:0] * g2e_pkg::K_INT;
		lat_pf_s2 <= lat_m[29:0] * g2e_pkg::K_FRAC;
		lon_pi_s2 <= lon_m[29:0] * g2e_pkg::K_INT;
		lon_pf_s2 <= lon_m[29:0] * g2e_pkg::K_FRAC;
		lat_neg_s2 <= lat_s1[30];
		lon_neg_s2 <= lon_s1[30];
		flip_s2 <= flip_s1;
		h_s2 <= h_s1;
		tag_s2 <= tag_s1;
	end

	// ---------------------------------------------------------------- stage 3
	always_comb begin
		lat_fr = (64'(lat_pf_s2) + 64'h8000_0000) >> 32;
		lon_fr = (64'(lon_pf_s2) + 64'h8000_0000) >> 32;
		lat_r = 64'(lat_pi_s2) + lat_fr;
		lon_r = 64'(lon_pi_s2) + lon_fr;
	end

	always_ff @(posedge clk) begin
		beat_s3.valid <= 1'b0;
		beat_s3.x_lat <= signed'(INV_GAIN);
		beat_s3.y_lat <= '0;
		beat_s3.z_lat <= lat_neg_s2 ? signed'(64'(-lat_r)) : signed'(lat_r);
		beat_s3.x_lon <= signed'(INV_GAIN);
		beat_s3.y_lon <= '0;
		beat_s3.z_lon <= lon_neg_s2 ? signed'(64'(-lon_r)) : signed'(lon_r);
		beat_s3.flip <= flip_s2;
		beat_s3.h <= h_s2;
		beat_s3.tag <= tag_s2;
	end

	always_comb begin
		chain[0] = beat_s3;
		chain[0].valid = vld_s3;
	end

	// ---------------------------------------------------------------- CORDIC chain
	for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
		g2e_cordic_cell #(.IDX(gi)) u_cell (
			.clk, .arst_n, .d(chain[gi]), .q(chain[gi+1])
		);
	end

	assign ce = chain[CORDIC_STAGES];
	assign cp = ce.x_lat;
	assign sp = ce.y_lat;
	assign cl = ce.flip ? -ce.x_lon : ce.x_lon;
	assign sl = ce.flip ? -ce.y_lon : ce.y_lon;

	// ---------------------------------------------------------------- 1 - e2 sin^2 lat
	g2e_mul #(.SH(60), .SW(SIDE_W)) u_mul_s2 (
		.clk, .arst_n, .valid(ce.valid), .a(g2e_pkg::mag64(sp)), .b(g2e_pkg::mag64(sp)),
		.neg(1'b0), .side({cp, sp, cl, sl, ce.h, ce.tag}),
		.res_valid(s2_v), .res(s2_p), .res_side(s2_side)
	);

	g2e_mul #(.SH(60), .SW(SIDE_W)) u_mul_e (
		.clk, .arst_n, .valid(s2_v), .a(g2e_pkg::E2_Q60), .b(s2_p), .neg(1'b0),
		.side(s2_side), .res_valid(e_v), .res(e_p), .res_side(e_side)
	);

	assign nv[0] = e_v;
	assign nw[0] = g2e_pkg::ONE_Q60 - e_p;
	assign ny[0] = g2e_pkg::ONE_Q60;
	assign nside[0] = e_side;

	for (genvar gn = 0; gn < NS; gn++) begin : g_newton
		g2e_newton_cell #(.SW(SIDE_W)) u_newton (
			.clk, .arst_n, .valid(nv[gn]), .w(nw[gn]), .y(ny[gn]), .side(nside[gn]),
			.res_valid(nv[gn+1]), .res_w(nw[gn+1]), .res_y(ny[gn+1]),
			.res_side(nside[gn+1])
		);
	end

	// ---------------------------------------------------------------- prime-vertical radius
	g2e_mul #(.SH(44), .SW(SIDE_W)) u_mul_n (
		.clk, .arst_n, .valid(nv[NS]), .a(g2e_pkg::A_MM), .b(ny[NS]), .neg(1'b0),
		.side(nside[NS]), .res_valid(n_v), .res(n16), .res_side(n_side)
	);

	assign {cp1, sp1, cl1, sl1, h1, tag1} = n_side;
	assign h16 = {{20{h1[27]}}, h1, 16'd0};
	assign sum_n = signed'(n16) + h16;

	g2e_mul #(.SH(60), .SW(129)) u_mul_t (
		.clk, .arst_n, .valid(n_v), .a(g2e_pkg::mag64(sum_n)), .b(g2e_pkg::mag64(cp1)),
		.neg(sum_n[63] ^ cp1[63]), .side({cl1, sl1, tag1}),
		.res_valid(t_v), .res(t_r), .res_side({cl2, sl2, tag2})
	);

	g2e_mul #(.SH(60), .SW(92)) u_mul_nb (
		.clk, .arst_n, .valid(n_v), .a(n16), .b(g2e_pkg::ONE_MINUS_E2_Q60), .neg(1'b0),
		.side({sp1, h1}), .res_valid(nb_v), .res(nb_r), .res_side({sp2, h2})
	);

	assign t2 = signed'(t_r);
	assign h16_2 = {{20{h2[27]}}, h2, 16'd0};
	assign zs = signed'(nb_r) + h16_2;

	// ---------------------------------------------------------------- x, y, z
	g2e_mul #(.SH(76), .SW(1)) u_mul_x (
		.clk, .arst_n, .valid(t_v), .a(g2e_pkg::mag64(t2)), .b(g2e_pkg::mag64(cl2)),
		.neg(t2[63] ^ cl2[63]), .side(tag2),
		.res_valid(fx_v), .res(fx_r), .res_side(fx_tag)
	);

	g2e_mul #(.SH(76), .SW(1)) u_mul_y (
		.clk, .arst_n, .valid(t_v), .a(g2e_pkg::mag64(t2)), .b(g2e_pkg::mag64(sl2)),
		.neg(t2[63] ^ sl2[63]), .side(tag2),
		.res_valid(fy_v), .res(fy_r), .res_side(fy_tag)
	);

	g2e_mul #(.SH(76), .SW(1)) u_mul_z (
		.clk, .arst_n, .valid(nb_v), .a(g2e_pkg::mag64(zs)), .b(g2e_pkg::mag64(sp2)),
		.neg(zs[63] ^ sp2[63]), .side(tag2),
		.res_valid(fz_v), .res(fz_r), .res_side(fz_tag)
	);

	// ---------------------------------------------------------------- origin and output
	always_ff @(posedge clk) begin
		if (fx_v && fx_tag) begin
			org_x_q <= signed'(fx_r);
			org_y_q <= signed'(fy_r);
			org_z_q <= signed'(fz_r);
		end
		offset_x_q <= sat35(65'(signed'(fx_r)) - 65'(org_x_q));
		offset_y_q <= sat35(65'(signed'(fy_r)) - 65'(org_y_q));
		offset_z_q <= sat35(65'(signed'(fz_r)) - 65'(org_z_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fx_v & ~fx_tag;
		end
	end

	assign done = done_q;
	assign offset_x = offset_x_q;
	assign offset_y = offset_y_q;
	assign offset_z = offset_z_q;

	// ---------------------------------------------------------------- assertions
	a_inject_excl: assert property (@(posedge clk) disable iff (!arst_n)
		inject |-> !take)
		else $error("origin beat injected together with a point beat");

	a_origin_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(fx_v && fx_tag) |-> inflight_q)
		else $error("origin result arrived with no origin beat in flight");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		fx_v |-> (fy_v && fz_v && fx_tag == fy_tag && fy_tag == fz_tag))
		else $error("x, y and z lanes out of step");

	a_point_done: assert property (@(posedge clk) disable iff (!arst_n)
		(fx_v && !fx_tag) |=> done)
		else $error("point result not strobed out");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> busy)
		else $error("configuration write did not start an origin update");

endmodule
